@@ design/ssd_pkg.sv @@
// shared types and constants for the sample descriptive statistics core
package ssd_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;

  localparam logic [62:0] VAR_MAX = {63{1'b1}};
  localparam logic [30:0] STD_MAX = {31{1'b1}};

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SINGLE = 2'd1;
  localparam logic [1:0] STAT_DROP   = 2'd2;
  localparam logic [1:0] STAT_SAT    = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] maximum;
    logic signed [31:0] minimum;
    logic signed [31:0] average;
    logic [62:0]        spread_squared;
    logic [30:0]        std_deviation;
    logic [10:0]        sample_count;
    logic [1:0]         status;
  } out_item_t;

endpackage

@@ design/ssd_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module ssd_div import ssd_pkg::*; #(
  parameter int DW = 74,
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [CW-1:0] rem_r;
  logic [CW-1:0] dvs_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [CW:0]   rem_sh;
  logic          ge;
  logic [CW:0]   diff;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(DW);
        quo_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[DW-2:0], ge};
        rem_r <= ge ? diff[CW-1:0] : rem_sh[CW-1:0];
        cnt_r <= cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/ssd_sqrt.sv @@
// bit-serial floor square root of a 64-bit value, two radicand bits per cycle
module ssd_sqrt import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] val_r;
  logic [31:0] root_r;
  logic [33:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] diff;

  assign rem_sh = {rem_r, val_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        val_r  <= value;
        root_r <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        val_r  <= {val_r[61:0], 2'b00};
        root_r <= {root_r[30:0], ge};
        rem_r  <= ge ? diff[33:0] : rem_sh[33:0];
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ design/sample_descriptive_statistics_core.sv @@
// top level: sample store, running statistics, second pass, divide and root
// sequence: samples load into the store; after the last one, mean divide,
//   pass over the store at one read per cycle, variance divide, 32-step
//   root; a set of one sample goes from the mean divide to the result
// throughput: one set at a time; samples of the next set load while the
//   previous result waits in the output register
// reset: synchronous active-low, clears control and running statistics;
//   the sample store is not cleared, only entries of the current set are read
module sample_descriptive_statistics_core import ssd_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);   // count width
  localparam int AIW = $clog2(MAX_SAMPLES);       // store index width
  localparam int SW  = 32 + AIW;                  // running sum width
  localparam int DW  = 64 + AIW;                  // squared deviation accumulator

  typedef enum logic [2:0] {
    ST_LOAD, ST_MEAN, ST_MEAN_WAIT, ST_PASS, ST_VDIV, ST_VDIV_WAIT,
    ST_SQRT_WAIT, ST_OUT
  } state_t;

  state_t state_r;

  // sample store
  logic [31:0] mem [MAX_SAMPLES];
  logic [31:0] rd_q_r;
  logic [AIW-1:0] rd_addr;

  // running statistics of the current set
  logic [CW-1:0]        count_r;
  logic signed [31:0]   max_r;
  logic signed [31:0]   min_r;
  logic signed [SW-1:0] sum_r;
  logic                 ovf_r;

  // results under construction
  logic signed [31:0] mean_r;
  logic [62:0]        var_r;
  logic [30:0]        sd_r;
  logic [1:0]         stat_r;

  // second pass pipeline
  logic [CW-1:0] iss_r;
  logic          rd_v_r;
  logic [31:0]   mag_r;
  logic          mag_v_r;
  logic [63:0]   sq_r;
  logic          sq_v_r;
  logic [DW-1:0] acc_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // divider shared by the mean and variance divides, and the root unit
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [CW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic          sqrt_start;
  logic          sqrt_done;
  logic [31:0]   sqrt_root;

  logic          in_take;
  logic          room;
  logic [SW-1:0] sum_mag;
  logic [31:0]   mean_nxt;
  logic signed [32:0] dev;
  logic          var_sat;
  logic [62:0]   var_nxt;
  logic          pass_end;
  logic          out_free;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_take   = in_valid && !in_stall;
  assign room      = count_r < CW'(MAX_SAMPLES);
  assign rd_addr   = iss_r[AIW-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  // magnitude of the sum for the mean divide, sign put back afterward
  assign sum_mag   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign mean_nxt  = sum_r[SW-1] ? (32'd0 - div_q[31:0]) : div_q[31:0];

  assign div_start    = (state_r == ST_MEAN) || (state_r == ST_VDIV);
  assign div_dividend = (state_r == ST_MEAN) ? DW'(sum_mag) : acc_r;
  assign div_divisor  = (state_r == ST_MEAN) ? count_r : (count_r - CW'(1));

  // quotient above the 63-bit range saturates
  assign var_sat = |div_q[DW-1:63];
  assign var_nxt = var_sat ? VAR_MAX : div_q[62:0];

  assign dev = $signed({rd_q_r[31], rd_q_r}) - $signed({mean_r[31], mean_r});

  assign pass_end = (iss_r == count_r) && !rd_v_r && !mag_v_r && !sq_v_r;

  ssd_div #(
    .DW (DW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  ssd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value ({1'b0, var_nxt}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // root starts as the variance quotient comes out of the divider
  assign sqrt_start = (state_r == ST_VDIV_WAIT) && div_done;

  // store write during load, registered read during the pass
  always_ff @(posedge clk) begin
    if (in_take && room) begin
      mem[count_r[AIW-1:0]] <= in_data.sample;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      max_r       <= 32'sh8000_0000;
      min_r       <= 32'sh7fff_ffff;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      iss_r       <= '0;
      rd_v_r      <= 1'b0;
      mag_v_r     <= 1'b0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a transaction leaving drops valid unless the next result loads now
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      // pass pipeline: read, deviation magnitude, square, accumulate
      rd_v_r  <= (state_r == ST_PASS) && (iss_r != count_r);
      mag_v_r <= rd_v_r;
      sq_v_r  <= mag_v_r;
      mag_r   <= dev[32] ? 32'(-dev) : dev[31:0];
      sq_r    <= mag_r * mag_r;
      if (sq_v_r) begin
        acc_r <= acc_r + DW'(sq_r);
      end

      case (state_r)
        ST_LOAD: begin
          if (in_take) begin
            if (room) begin
              count_r <= count_r + CW'(1);
              if (in_data.sample > max_r) max_r <= in_data.sample;
              if (in_data.sample < min_r) min_r <= in_data.sample;
              sum_r <= sum_r + {{(SW-32){in_data.sample[31]}}, in_data.sample};
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_data.last) begin
              state_r <= ST_MEAN;
            end
          end
        end
        ST_MEAN: begin
          state_r <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_done) begin
            mean_r <= mean_nxt;
            if (count_r < CW'(2)) begin
              // single sample: no spread
              var_r   <= '0;
              sd_r    <= '0;
              stat_r  <= STAT_SINGLE;
              state_r <= ST_OUT;
            end else begin
              iss_r   <= '0;
              acc_r   <= '0;
              state_r <= ST_PASS;
            end
          end
        end
        ST_PASS: begin
          if (iss_r != count_r) begin
            iss_r <= iss_r + CW'(1);
          end else if (pass_end) begin
            state_r <= ST_VDIV;
          end
        end
        ST_VDIV: begin
          state_r <= ST_VDIV_WAIT;
        end
        ST_VDIV_WAIT: begin
          if (div_done) begin
            var_r   <= var_nxt;
            stat_r  <= var_sat ? STAT_SAT : (ovf_r ? STAT_DROP : STAT_OK);
            state_r <= ST_SQRT_WAIT;
          end
        end
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            sd_r    <= sqrt_root[31] ? STD_MAX : sqrt_root[30:0];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_data_r.maximum         <= max_r;
            out_data_r.minimum         <= min_r;
            out_data_r.average         <= mean_r;
            out_data_r.spread_squared  <= var_r;
            out_data_r.std_deviation   <= sd_r;
            out_data_r.sample_count    <= 11'(count_r);
            out_data_r.status          <= stat_r;
            // start a fresh set
            count_r <= '0;
            max_r   <= 32'sh8000_0000;
            min_r   <= 32'sh7fff_ffff;
            sum_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/ssd_checker.sv @@
// checker for the statistics core: predicts each set result and compares transactions
module ssd_checker import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = MAX_SAMPLES_DEF;

  logic signed [31:0] kept [DEPTH];
  int unsigned        kept_n;
  logic signed [31:0] top_val, bottom_val;
  longint             total;
  bit                 dropped;
  out_item_t          stats_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic new_set();
    kept_n = 0;
    top_val = 32'sh8000_0000;
    bottom_val = 32'sh7fff_ffff;
    total = 0;
    dropped = 0;
  endtask

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic out_item_t summarize();
    out_item_t    r;
    longint       mean, d;
    logic [63:0]  mag, root;
    logic [127:0] acc, quot;
    acc = 0;
    mean = total / longint'(kept_n);
    r.maximum = top_val;
    r.minimum = bottom_val;
    r.average = mean[31:0];
    r.sample_count = kept_n[10:0];
    r.spread_squared = 0;
    r.status = STAT_OK;
    if (kept_n < 2) begin
      r.status = STAT_SINGLE;
    end else begin
      for (int i = 0; i < kept_n; i++) begin
        d = longint'(kept[i]) - mean;
        mag = (d < 0) ? -d : d;
        acc += {64'd0, mag} * {64'd0, mag};
      end
      quot = acc / (kept_n - 1);
      if (quot[127:63] != 0) begin
        r.spread_squared = VAR_MAX;
        r.status = STAT_SAT;
      end else begin
        r.spread_squared = quot[62:0];
      end
    end
    if (r.status == STAT_OK && dropped) r.status = STAT_DROP;
    root = floor_root({1'b0, r.spread_squared});
    r.std_deviation = (root > STD_MAX) ? STD_MAX : root[30:0];
    return r;
  endfunction

  initial new_set();

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $display("%0t unexpected result transaction", $realtime);
          fail_count++;
        end else begin
          want = stats_due.pop_front();
          if (out_data.maximum !== want.maximum)
            report("maximum", out_data.maximum, want.maximum);
          if (out_data.minimum !== want.minimum)
            report("minimum", out_data.minimum, want.minimum);
          if (out_data.average !== want.average)
            report("average", out_data.average, want.average);
          if (out_data.spread_squared !== want.spread_squared)
            report("spread_squared", out_data.spread_squared, want.spread_squared);
          if (out_data.std_deviation !== want.std_deviation)
            report("std_deviation", out_data.std_deviation, want.std_deviation);
          if (out_data.sample_count !== want.sample_count)
            report("sample_count", out_data.sample_count, want.sample_count);
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
        end
      end
      if (in_valid && !in_stall) begin
        if (kept_n < DEPTH) begin
          kept[kept_n] = in_data.sample;
          kept_n++;
          if (in_data.sample > top_val) top_val = in_data.sample;
          if (in_data.sample < bottom_val) bottom_val = in_data.sample;
          total += longint'(in_data.sample);
        end else begin
          dropped = 1;
        end
        if (in_data.last) begin
          stats_due.push_back(summarize());
          new_set();
        end
      end
      pending = stats_due.size();
    end
  end
endmodule

@@ tb/testbench.sv @@
// testbench top: stimulus, clock, reset, watchdog and verdict for the statistics core
module testbench import ssd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;  // longest set plus long hold-off, with margin
  localparam int HOLD_CYCLES = 3000;

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  int        fail_count, pending;
  int        idle_cycles;
  bit        hold_req;
  bit        send_quick;   // sender burst mode, no gaps
  int        sent_total;

  sample_descriptive_statistics_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ssd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles in a row with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one sample transaction; gap drawn per item, zero in burst mode
  task automatic push_sample(input logic signed [31:0] value, input logic is_last);
    int gap;
    gap = send_quick ? 0 : $urandom_range(15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data.sample = value;
    in_data.last = is_last;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sent_total++;
  endtask

  task automatic end_offer();
    @(negedge clk);
    in_valid = 0;
  endtask

  // random value: full range, small values near zero, the extremes, or a medium range around zero
  function automatic logic signed [31:0] draw_value(input int flavor);
    case (flavor)
      0: return $urandom;
      1: return $signed($urandom_range(200000)) - 100000;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic send_set(input int count, input int flavor);
    for (int i = 0; i < count; i++)
      push_sample(draw_value(flavor), i == count - 1);
  endtask

  // receiver: per result a random hold-off, with fast stretches and one long hold
  initial begin
    int  w;
    bit  fast;
    int  served;
    out_stall = 1;
    served = 0;
    fast = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      if (served % 20 == 0) fast = ($urandom_range(2) == 0);
      w = fast ? 0 : $urandom_range(15);
      if (w > 0) begin
        out_stall = 1;
        repeat (w) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  initial begin
    int flavor, len;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    hold_req = 0;
    send_quick = 0;
    sent_total = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // directed: single-sample sets at the extremes and at zero
    push_sample(32'sh7fff_ffff, 1);
    push_sample(32'sh8000_0000, 1);
    push_sample(32'sh0000_0000, 1);
    // two extremes: variance comes just under the saturation limit
    push_sample(32'sh8000_0000, 0);
    push_sample(32'sh7fff_ffff, 1);
    // constant set: zero variance
    repeat (3) push_sample(32'sh0001_0000, 0);
    push_sample(32'sh0001_0000, 1);
    // negative mean truncates toward zero
    push_sample(-32'sd1, 0);
    push_sample(-32'sd2, 1);
    push_sample(32'sd1, 0);
    push_sample(32'sd2, 1);
    // fractional values and one near the maximum: wide spread
    push_sample(32'sh0000_8000, 0);
    push_sample(-32'sh0000_8000, 0);
    push_sample(32'sh0003_4000, 0);
    push_sample(32'sh7fff_fffe, 1);
    // all-ones / alternating bit patterns
    push_sample(32'sh5555_5555, 0);
    push_sample(32'shaaaa_aaaa, 0);
    push_sample(-32'sd1, 1);
    end_offer();
    wait (pending == 0);

    // long receiver hold while sets keep coming, so the input backs up
    hold_req = 1;
    send_quick = 1;
    for (int s = 0; s < 4; s++) send_set(30, 3);
    send_quick = 0;
    end_offer();
    wait (pending == 0);

    // random sets, mostly short
    while (sent_total < 500) begin
      flavor = $urandom_range(3);
      len = ($urandom_range(5) == 0) ? $urandom_range(2) + 1 : $urandom_range(40) + 1;
      send_quick = ($urandom_range(3) == 0);
      send_set(len, flavor);
      if ($urandom_range(15) == 0) begin
        end_offer();
        wait (pending == 0);
      end
    end
    send_quick = 1;
    // full store plus a dropped sample: status dropped
    send_set(MAX_SAMPLES_DEF + 1, 1);
    send_quick = 0;
    send_set(5, 0);
    end_offer();

    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
